[hw/rtl/b64d_pkg.sv]
// Shared types, codes and the character map for the base64url stream decoder.
// No dependencies; imported by b64d_step and base64url_stream_decoder.
package b64d_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned LenW   = 16;
  localparam int unsigned SextW  = 6;
  localparam int unsigned CountW = 3;

  localparam logic [LenW-1:0] MaxOutputBytesReset = 16'hffff;

  localparam logic [CharW-1:0] CharNul    = 8'h00;
  localparam logic [CharW-1:0] CharDollar = 8'h24;
  localparam logic [CharW-1:0] CharColon  = 8'h3a;
  localparam logic [CharW-1:0] CharDash   = 8'h2d;
  localparam logic [CharW-1:0] CharUnder  = 8'h5f;

  localparam logic [SextW-1:0] SextDash  = 6'd62;
  localparam logic [SextW-1:0] SextUnder = 6'd63;
  localparam logic [SextW-1:0] LowerBase = 6'd26;
  localparam logic [SextW-1:0] DigitBase = 6'd52;

  typedef enum logic [KindW-1:0] {
    KindData    = 2'd0,
    KindDone    = 2'd1,
    KindInvalid = 2'd2,
    KindTooBig  = 2'd3
  } kind_e;

  // Per-string decoder state
  typedef struct packed {
    logic [SextW-1:0]  leftover;
    logic [CountW-1:0] count;
    logic [LenW-1:0]   given;
    logic              error;
  } dec_state_t;

  // One result word from the step logic
  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [CharW-1:0] data;
    logic [LenW-1:0]  length;
  } dec_result_t;

  // Map a character to {in_alphabet, sextet}
  function automatic logic [SextW:0] sextet_of(input logic [CharW-1:0] c);
    logic [SextW:0] r;
    r = '0;
    if (c inside {["A":"Z"]}) begin
      r = {1'b1, SextW'(c - CharW'("A"))};
    end else if (c inside {["a":"z"]}) begin
      r = {1'b1, SextW'(c - CharW'("a")) + LowerBase};
    end else if (c inside {["0":"9"]}) begin
      r = {1'b1, SextW'(c - CharW'("0")) + DigitBase};
    end else if (c == CharDash) begin
      r = {1'b1, SextDash};
    end else if (c == CharUnder) begin
      r = {1'b1, SextUnder};
    end
    return r;
  endfunction

endpackage

[hw/rtl/b64d_step.sv]
// Combinational step of the decoder: one character against the current state.
// Depends on b64d_pkg for the state and result structs and the character map.
module b64d_step
  import b64d_pkg::*;
(
  input  logic [CharW-1:0] char_i,
  input  logic [LenW-1:0]  limit_i,
  input  dec_state_t       state_i,
  output dec_state_t       state_o,
  output dec_result_t      result_o
);

  logic             is_end;
  logic [SextW:0]   sext;
  logic [11:0]      acc;
  logic [3:0]       bits;
  logic [3:0]       rem;
  logic [11:0]      mask;

  assign is_end = (char_i == CharNul) || (char_i == CharDollar) || (char_i == CharColon);
  assign sext   = sextet_of(char_i);
  assign acc    = {state_i.leftover, sext[SextW-1:0]};
  assign bits   = 4'(state_i.count) + 4'd6;
  assign rem    = bits - 4'd8;
  assign mask   = (12'd1 << rem) - 12'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '{valid: 1'b0, kind: KindData, data: '0, length: '0};
    if (is_end) begin
      // End marker: report and clear, silently if an error was already given
      state_o = '0;
      if (!state_i.error) begin
        result_o.valid = 1'b1;
        if (state_i.count >= CountW'(6)) begin
          result_o.kind = KindInvalid;
        end else begin
          result_o.kind   = KindDone;
          result_o.length = state_i.given;
        end
      end
    end else if (!state_i.error) begin
      if (!sext[SextW]) begin
        // Drop the rest of the string after a bad character
        state_o.error  = 1'b1;
        result_o.valid = 1'b1;
        result_o.kind  = KindInvalid;
      end else if (bits >= 4'd8) begin
        result_o.valid = 1'b1;
        if (state_i.given >= limit_i) begin
          state_o.error = 1'b1;
          result_o.kind = KindTooBig;
        end else begin
          result_o.kind  = KindData;
          result_o.data  = 8'(acc >> rem);
          state_o.leftover = SextW'(acc & mask);
          state_o.count    = CountW'(rem);
          state_o.given    = state_i.given + LenW'(1);
        end
      end else begin
        // Hold the bits until a full byte is there
        state_o.leftover = sext[SextW-1:0];
        state_o.count    = CountW'(bits);
      end
    end
  end

endmodule

[hw/rtl/base64url_stream_decoder.sv]
// Path: an accepted character goes through the input register, then the step logic
// into the result register.
// Throughput: one character per cycle unless the result is stalled; the state
// update of the step logic is combinational, and a stalled result holds the pipeline.
// Reset: control and string state clear; limit_q loads MaxOutputBytesInit (default 65535).
// Top level of the base64url stream decoder; depends on b64d_pkg and b64d_step.
module base64url_stream_decoder
  import b64d_pkg::*;
#(
  parameter logic [LenW-1:0] MaxOutputBytesInit = MaxOutputBytesReset
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] char_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KindW-1:0] kind_o,
  output logic [CharW-1:0] byte_out_o,
  output logic [LenW-1:0]  length_o
);

  logic [LenW-1:0]  limit_q;
  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  dec_state_t       state_q, state_d;
  dec_result_t      result;
  logic             out_valid_q;
  kind_e            kind_q;
  logic [CharW-1:0] byte_q;
  logic [LenW-1:0]  length_q;
  logic             advance;

  // Advance the held word when the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Output limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= MaxOutputBytesInit;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
    end
  end

  b64d_step u_step (
    .char_i   (char_q),
    .limit_i  (limit_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: load a new word, drop a taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      kind_q   <= result.kind;
      byte_q   <= result.data;
      length_q <= result.length;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign byte_out_o  = byte_q;
  assign length_o    = length_q;

  // Checks
  a_count_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.count[0] && (state_q.count <= CountW'(6)))
    else $error("bit count left the set 0, 2, 4, 6");

  a_quiet_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.error |-> !result.valid)
    else $error("result produced while swallowing a failed string");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q != KindData) |-> (byte_q == '0))
    else $error("byte field set on a non-data result");

  a_length_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q != KindDone) |-> (length_q == '0))
    else $error("length field set on a result other than done");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(byte_q) && $stable(kind_q))
    else $error("pending result overwritten while stalled");

endmodule
